// File: rtl/tlbb_pkg.sv
`timescale 1ns / 1ps

package tlbb_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W     = 4;
    localparam int LEN_W      = 24;
    localparam int CNT_W      = 32;
    localparam int MASK_W     = 8;
    localparam int SLOT_IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK  = 2'd2;

    localparam logic [CNT_W-1:0] GLOBAL_LIMIT_RST = 32'd67108864;
    localparam logic [CNT_W-1:0] SLOT_LIMIT_RST   = 32'd16777216;

    localparam logic MODE_ACQUIRE = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // classified command handed from front to back
    typedef struct packed {
        logic               mode;
        logic               active;    // nonzero length on an enabled slot
        logic               in_range;
        logic [SLOT_IW-1:0] idx;
        logic [LEN_W-1:0]   len;
    } t_cmd;

endpackage

// File: rtl/tlbb_req_if.sv
`timescale 1ns / 1ps

interface tlbb_req_if;
    import tlbb_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  byte_len;

    modport source (output valid, output mode, output slot, output byte_len, input ready);
    modport sink   (input valid, input mode, input slot, input byte_len, output ready);
endinterface

// File: rtl/tlbb_rsp_if.sv
`timescale 1ns / 1ps

interface tlbb_rsp_if;
    import tlbb_pkg::*;

    logic             valid;
    logic             ready;
    logic             granted;
    logic [CNT_W-1:0] slot_count;
    logic [CNT_W-1:0] total_count;

    modport source (output valid, output granted, output slot_count, output total_count,
                    input ready);
    modport sink   (input valid, input granted, input slot_count, input total_count,
                    output ready);
endinterface

// File: rtl/tlbb_front.sv
`timescale 1ns / 1ps

module tlbb_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tlbb_pkg::MASK_W-1:0] i_enable_mask,
    tlbb_req_if.sink                    i_req,
    output logic                        o_q_valid,
    output tlbb_pkg::t_cmd              o_q_cmd,
    input  logic                        i_q_pop
);
    import tlbb_pkg::*;

    localparam int Q_DEPTH = 2;

    t_cmd        r_q [Q_DEPTH];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;

    t_cmd        w_cmd;
    logic        w_push;
    logic        w_pop;
    logic        w_in_range;
    logic        w_enabled;

    assign i_req.ready = (r_count != 2'(Q_DEPTH));
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = i_q_pop && (r_count != 2'd0);

    always_comb begin
        w_in_range = ({1'b0, i_req.slot} < 5'(SLOT_COUNT));
        w_enabled  = w_in_range && ({1'b0, i_req.slot} < 5'(MASK_W))
                     && i_enable_mask[i_req.slot[2:0]];
        w_cmd.mode     = i_req.mode;
        w_cmd.active   = w_enabled && (i_req.byte_len != '0);
        w_cmd.in_range = w_in_range;
        w_cmd.idx      = i_req.slot[SLOT_IW-1:0];
        w_cmd.len      = i_req.byte_len;
    end

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    assign o_q_valid = (r_count != 2'd0);
    assign o_q_cmd   = r_q[r_rd_ptr];

endmodule

// File: rtl/tlbb_back.sv
`timescale 1ns / 1ps

module tlbb_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [tlbb_pkg::CNT_W-1:0] i_global_limit,
    input  logic [tlbb_pkg::CNT_W-1:0] i_slot_limit,
    input  logic                       i_q_valid,
    input  tlbb_pkg::t_cmd             i_q_cmd,
    output logic                       o_q_pop,
    tlbb_rsp_if.source                 o_rsp
);
    import tlbb_pkg::*;

    logic [CNT_W-1:0] r_slot_cnt [SLOT_COUNT];
    logic [CNT_W-1:0] r_total;

    logic             r_out_valid;
    logic             r_granted;
    logic [CNT_W-1:0] r_slot_out;
    logic [CNT_W-1:0] r_total_out;

    logic             w_take;
    logic [CNT_W-1:0] w_local;
    logic [CNT_W:0]   w_sum_local;
    logic [CNT_W:0]   w_sum_total;
    logic [CNT_W-1:0] w_len;
    logic             w_fits;
    logic             w_update;
    logic             w_granted;
    logic [CNT_W-1:0] n_local;
    logic [CNT_W-1:0] n_total;

    assign o_q_pop = i_q_valid && (!r_out_valid || o_rsp.ready);
    assign w_take  = o_q_pop;

    always_comb begin
        w_len       = CNT_W'(i_q_cmd.len);
        w_local     = r_slot_cnt[i_q_cmd.idx];
        w_sum_local = {1'b0, w_local} + {1'b0, w_len};
        w_sum_total = {1'b0, r_total} + {1'b0, w_len};
        w_fits      = (w_sum_total <= {1'b0, i_global_limit})
                      && (w_sum_local <= {1'b0, i_slot_limit});
        w_granted   = 1'b1;
        w_update    = 1'b0;
        n_local     = w_local;
        n_total     = r_total;
        if (i_q_cmd.active) begin
            if (i_q_cmd.mode == MODE_ACQUIRE) begin
                w_granted = w_fits;
                w_update  = w_fits;
                n_local   = w_sum_local[CNT_W-1:0];
                n_total   = w_sum_total[CNT_W-1:0];
            end else begin
                // each level saturates at zero on its own
                w_update = 1'b1;
                n_local  = (w_local > w_len) ? (w_local - w_len) : '0;
                n_total  = (r_total > w_len) ? (r_total - w_len) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_cnt[i] <= '0;
            end
            r_total <= '0;
        end else if (w_take && w_update) begin
            r_slot_cnt[i_q_cmd.idx] <= n_local;
            r_total                 <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_granted   <= w_granted;
            r_slot_out  <= i_q_cmd.in_range ? (w_update ? n_local : w_local) : '0;
            r_total_out <= w_update ? n_total : r_total;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.granted     = r_granted;
    assign o_rsp.slot_count  = r_slot_out;
    assign o_rsp.total_count = r_total_out;

endmodule

// File: rtl/two_level_byte_budget_top.sv
// The result is registered: an accepted item is written into the queue, and its
// result is captured in the output register when the back stage takes it.
// Throughput: one item per cycle while the response side is ready; the back
// stage reads, checks and writes the slot and total counters in the same cycle, feeding the next item.
// A two-entry queue separates classification from counter update.
// Synchronous active-low reset clears all counters, the queue and the output
// register, restores the limits to their defaults and disables all slots.
`timescale 1ns / 1ps

module two_level_byte_budget_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tlbb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tlbb_pkg::CNT_W-1:0]     i_cfg_data,
    tlbb_req_if.sink                       i_req,
    tlbb_rsp_if.source                     o_rsp
);
    import tlbb_pkg::*;

    logic [CNT_W-1:0]  r_global_limit;
    logic [CNT_W-1:0]  r_slot_limit;
    logic [MASK_W-1:0] r_enable_mask;

    logic              w_q_valid;
    t_cmd              w_q_cmd;
    logic              w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global_limit <= GLOBAL_LIMIT_RST;
            r_slot_limit   <= SLOT_LIMIT_RST;
            r_enable_mask  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GLOBAL_LIMIT: r_global_limit <= i_cfg_data;
                CFG_SLOT_LIMIT:   r_slot_limit   <= i_cfg_data;
                CFG_ENABLE_MASK:  r_enable_mask  <= i_cfg_data[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tlbb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_enable_mask (r_enable_mask),
        .i_req         (i_req),
        .o_q_valid     (w_q_valid),
        .o_q_cmd       (w_q_cmd),
        .i_q_pop       (w_q_pop)
    );

    tlbb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_global_limit (r_global_limit),
        .i_slot_limit   (r_slot_limit),
        .i_q_valid      (w_q_valid),
        .i_q_cmd        (w_q_cmd),
        .o_q_pop        (w_q_pop),
        .o_rsp          (o_rsp)
    );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tlbb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam logic [SLOT_W-1:0]    SLOT_MAX       = '1;
    localparam logic [LEN_W-1:0]     LEN_MAX        = '1;
    localparam logic [CNT_W-1:0]     CNT_MAX        = '1;

    typedef struct packed {
        logic             granted;
        logic [CNT_W-1:0] slot_count;
        logic [CNT_W-1:0] total_count;
    } t_admission;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CNT_W-1:0]     i_cfg_data;

    tlbb_req_if req_ch ();
    tlbb_rsp_if rsp_ch ();

    two_level_byte_budget_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the block's counters and registers
    logic [CNT_W-1:0]  held_bytes [SLOT_COUNT];
    logic [CNT_W-1:0]  held_total;
    logic [CNT_W-1:0]  lim_global;
    logic [CNT_W-1:0]  lim_slot;
    logic [MASK_W-1:0] en_mask;

    t_admission admission_q [$];
    int         err_cnt         = 0;
    bit         idle_on         = 1'b1;
    int         rsp_hold_cycles = 0;

    function automatic t_admission apply_admission(input logic mode,
                                                   input logic [SLOT_W-1:0] slot,
                                                   input logic [LEN_W-1:0] len);
        t_admission         r;
        logic               in_rng;
        logic [SLOT_IW-1:0] idx;
        logic [CNT_W:0]     sum_total;
        logic [CNT_W:0]     sum_slot;
        in_rng    = (slot < SLOT_COUNT);
        idx       = slot[SLOT_IW-1:0];
        r.granted = 1'b1;
        if (in_rng && len != '0 && en_mask[idx]) begin
            sum_total = {1'b0, held_total} + len;
            sum_slot  = {1'b0, held_bytes[idx]} + len;
            if (mode == MODE_ACQUIRE) begin
                if (sum_total > {1'b0, lim_global} || sum_slot > {1'b0, lim_slot}) begin
                    r.granted = 1'b0;
                end else begin
                    held_total      = sum_total[CNT_W-1:0];
                    held_bytes[idx] = sum_slot[CNT_W-1:0];
                end
            end else begin
                // each level floors at zero independently
                held_bytes[idx] = (held_bytes[idx] > len) ? held_bytes[idx] - len : '0;
                held_total      = (held_total > len) ? held_total - len : '0;
            end
        end
        r.slot_count  = in_rng ? held_bytes[idx] : '0;
        r.total_count = held_total;
        return r;
    endfunction

    // one item; valid stays up after acceptance so back-to-back items need no gap
    task automatic send_item(input logic mode, input logic [SLOT_W-1:0] slot,
                             input logic [LEN_W-1:0] len);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.mode     <= mode;
        req_ch.slot     <= slot;
        req_ch.byte_len <= len;
        do @(posedge i_clk); while (!req_ch.ready);
        admission_q.push_back(apply_admission(mode, slot, len));
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (admission_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_GLOBAL_LIMIT: lim_global = val;
            CFG_SLOT_LIMIT:   lim_slot   = val;
            CFG_ENABLE_MASK:  en_mask    = val[MASK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [CNT_W-1:0] gl, input logic [CNT_W-1:0] sl,
                              input logic [CNT_W-1:0] mask_word);
        wait_drained();
        write_reg(CFG_GLOBAL_LIMIT, gl);
        write_reg(CFG_SLOT_LIMIT, sl);
        write_reg(CFG_ENABLE_MASK, mask_word);
        i_cfg_we <= 1'b0;
    endtask

    // reset defaults: every slot disabled, so everything bypasses
    task automatic test_reset_bypass();
        send_item(MODE_ACQUIRE, 4'd0, 24'd100);
        send_item(MODE_RELEASE, 4'd3, LEN_MAX);
        send_item(MODE_ACQUIRE, SLOT_MAX, 24'd5);
        send_item(MODE_ACQUIRE, 4'd1, 24'd0);
    endtask

    task automatic test_limit_edges();
        set_limits(32'h0200_0000, 32'h0100_0000, 32'h0000_00FF);
        send_item(MODE_ACQUIRE, 4'd0, LEN_MAX);
        send_item(MODE_ACQUIRE, 4'd0, 24'd1);       // lands exactly on slot limit
        send_item(MODE_ACQUIRE, 4'd0, 24'd1);       // refused by slot limit
        send_item(MODE_ACQUIRE, 4'd1, LEN_MAX);
        send_item(MODE_ACQUIRE, 4'd2, 24'd2);       // refused by global limit
        send_item(MODE_ACQUIRE, 4'd2, 24'd1);       // exactly on global limit
        send_item(MODE_ACQUIRE, 4'd3, 24'd0);
        send_item(MODE_ACQUIRE, 4'd9, 24'd5);
        send_item(MODE_RELEASE, 4'd0, LEN_MAX);
        send_item(MODE_RELEASE, 4'd0, 24'd10);      // more than held
        send_item(MODE_RELEASE, 4'd1, LEN_MAX);
        send_item(MODE_RELEASE, 4'd5, 24'd100);     // empty slot, total already at zero
        send_item(MODE_ACQUIRE, 4'd6, 24'h80_0000);
    endtask

    // limits dropped under current holdings; slot 6 disabled but keeps its count
    task automatic test_lowered_limits();
        set_limits(32'd0, 32'd0, 32'h0000_000F);
        send_item(MODE_ACQUIRE, 4'd2, 24'd1);
        send_item(MODE_RELEASE, 4'd2, 24'd1);
        send_item(MODE_ACQUIRE, 4'd6, 24'd7);
        send_item(MODE_RELEASE, 4'd6, 24'd7);
    endtask

    task automatic test_wide_limits();
        wait_drained();
        write_reg(CFG_UNUSED_IDX, $urandom);
        set_limits(CNT_MAX, CNT_MAX, 32'hFFFF_FFFF);
        send_item(MODE_ACQUIRE, 4'd7, LEN_MAX);
        send_item(MODE_RELEASE, 4'd7, LEN_MAX);
        send_item(MODE_ACQUIRE, 4'd0, 24'd1);
    endtask

    task automatic test_random_traffic(input int n_items, input logic [CNT_W-1:0] gl,
                                       input logic [CNT_W-1:0] sl,
                                       input logic [CNT_W-1:0] mask_word);
        logic              m;
        logic [SLOT_W-1:0] s;
        logic [LEN_W-1:0]  l;
        logic [CNT_W-1:0]  span;
        int                pick;
        set_limits(gl, sl, mask_word);
        // typical lengths scale with the slot limit so both grants and refusals occur
        span = ((sl >> 2) > {8'd0, LEN_MAX}) ? {8'd0, LEN_MAX} : ((sl >> 2) | 32'd1);
        for (int i = 0; i < n_items; i++) begin
            m = ($urandom_range(0, 99) < 35) ? MODE_RELEASE : MODE_ACQUIRE;
            s = ($urandom_range(0, 99) < 85) ? SLOT_W'($urandom_range(0, SLOT_COUNT - 1))
                                             : SLOT_W'($urandom_range(SLOT_COUNT, SLOT_MAX));
            pick = $urandom_range(0, 99);
            if (pick < 8)
                l = '0;
            else if (pick < 25)
                l = LEN_W'($urandom);
            else
                l = LEN_W'($urandom_range(1, span));
            send_item(m, s, l);
        end
    endtask

    // output held off long enough for the internal queue to fill and stall the input
    task automatic test_backpressure();
        wait_drained();
        idle_on         = 1'b0;
        rsp_hold_cycles = 300;
        for (int i = 0; i < 40; i++)
            send_item((i % 3 == 2) ? MODE_RELEASE : MODE_ACQUIRE,
                      SLOT_W'($urandom_range(0, SLOT_MAX)), LEN_W'($urandom_range(0, 24'hFFFF)));
        idle_on = 1'b1;
    endtask

    // response check, oldest expectation first
    always @(posedge i_clk) begin : check_rsp
        t_admission want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (admission_q.size() == 0) begin
                $error("result with no item outstanding");
                err_cnt++;
            end else begin
                want = admission_q.pop_front();
                if (rsp_ch.granted !== want.granted) begin
                    $error("granted: expected %0d, got %0d", want.granted, rsp_ch.granted);
                    err_cnt++;
                end
                if (rsp_ch.slot_count !== want.slot_count) begin
                    $error("slot_count: expected %0d, got %0d",
                           want.slot_count, rsp_ch.slot_count);
                    err_cnt++;
                end
                if (rsp_ch.total_count !== want.total_count) begin
                    $error("total_count: expected %0d, got %0d",
                           want.total_count, rsp_ch.total_count);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (rsp_hold_cycles) @(posedge i_clk);
                rsp_hold_cycles = 0;
                rsp_ch.ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_GLOBAL_LIMIT;
        i_cfg_data      <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.mode     <= MODE_ACQUIRE;
        req_ch.slot     <= '0;
        req_ch.byte_len <= '0;
        for (int i = 0; i < SLOT_COUNT; i++)
            held_bytes[i] = '0;
        held_total = '0;
        lim_global = GLOBAL_LIMIT_RST;
        lim_slot   = SLOT_LIMIT_RST;
        en_mask    = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_bypass();
        test_limit_edges();
        test_lowered_limits();
        test_wide_limits();
        test_random_traffic(180, $urandom_range(32'h0100_0000, 32'h0400_0000),
                            $urandom_range(32'h0040_0000, 32'h0200_0000), $urandom);
        test_random_traffic(140, $urandom_range(0, 32'h0010_0000),
                            $urandom_range(0, 32'h0008_0000), 32'h0000_00FF);
        test_random_traffic(100, CNT_MAX, CNT_MAX, $urandom);
        test_backpressure();
        test_random_traffic(80, $urandom, $urandom_range(32'h0080_0000, 32'h0300_0000),
                            32'h0000_00FF);
        idle_on = 1'b0;
        test_random_traffic(200, $urandom_range(32'h0200_0000, 32'h0800_0000),
                            $urandom_range(32'h0100_0000, 32'h0200_0000), $urandom);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
